>>> rtl/fltc_pkg.sv
// Shared types and codes of the face list to CSR pattern unit.
package fltc_pkg;

  localparam int SLOT_BITS = 8;
  localparam int CELL_BITS = 12;
  localparam int VAL_BITS  = 16;
  localparam int STS_BITS  = 3;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [2:0] SEL_ROW   = 3'd0;
  localparam logic [2:0] SEL_COL   = 3'd1;
  localparam logic [2:0] SEL_DIAG  = 3'd2;
  localparam logic [2:0] SEL_OSLOT = 3'd3;
  localparam logic [2:0] SEL_NSLOT = 3'd4;

  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_ROW   = 3'd1;
  localparam logic [2:0] STS_FULL  = 3'd2;
  localparam logic [2:0] STS_CELL  = 3'd3;
  localparam logic [2:0] STS_RANGE = 3'd4;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_CHK_RD  = 5'd1;
  localparam logic [4:0] ST_CHK_EV  = 5'd2;
  localparam logic [4:0] ST_INIT    = 5'd3;
  localparam logic [4:0] ST_CNT_RD  = 5'd4;
  localparam logic [4:0] ST_CNT_O   = 5'd5;
  localparam logic [4:0] ST_CNT_OW  = 5'd6;
  localparam logic [4:0] ST_CNT_N   = 5'd7;
  localparam logic [4:0] ST_CNT_NW  = 5'd8;
  localparam logic [4:0] ST_PRE_RD  = 5'd9;
  localparam logic [4:0] ST_PRE_W   = 5'd10;
  localparam logic [4:0] ST_LOW_RD  = 5'd11;
  localparam logic [4:0] ST_LOW_A   = 5'd12;
  localparam logic [4:0] ST_LOW_W   = 5'd13;
  localparam logic [4:0] ST_DIAG_RD = 5'd14;
  localparam logic [4:0] ST_DIAG_W  = 5'd15;
  localparam logic [4:0] ST_UP_RD   = 5'd16;
  localparam logic [4:0] ST_UP_A    = 5'd17;
  localparam logic [4:0] ST_UP_W    = 5'd18;
  localparam logic [4:0] ST_DONE    = 5'd19;
  localparam logic [4:0] ST_FAIL    = 5'd20;
  localparam logic [4:0] ST_READ    = 5'd21;

  typedef struct packed {
    logic [4:0] op;
    logic       accept;
    logic       idx_clr;
    logic       idx_inc;
  } cmd_t;

  typedef struct packed {
    logic faces_end;
    logic cells_end;
    logic bad_cell;
    logic face_full;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/fltc_ram.sv
// Generic simple dual-port RAM with registered read.
module fltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fltc_ctrl.sv
// Controller state machine that sequences the load, build and read work.
module fltc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  input  fltc_pkg::sts_t   sts,
  output logic             in_ready,
  output fltc_pkg::cmd_t   cmd
);
  import fltc_pkg::*;

  logic [4:0] state_r, state_nxt;
  logic       acc;

  assign in_ready = (state_r == ST_IDLE) && !sts.out_busy;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = state_r;
    cmd.accept  = acc;
    cmd.idx_clr = 1'b0;
    cmd.idx_inc = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_mode == MODE_BUILD) begin
          state_nxt   = ST_CHK_RD;
          cmd.idx_clr = 1'b1;
        end else if (acc && in_mode == MODE_READ) begin
          state_nxt = ST_READ;
        end
      end
      ST_CHK_RD: begin
        if (sts.faces_end) begin
          state_nxt   = ST_INIT;
          cmd.idx_clr = 1'b1;
        end else begin
          state_nxt = ST_CHK_EV;
        end
      end
      ST_CHK_EV: begin
        if (sts.bad_cell) begin
          state_nxt = ST_FAIL;
        end else begin
          state_nxt   = ST_CHK_RD;
          cmd.idx_inc = 1'b1;
        end
      end
      ST_INIT: begin
        if (sts.cells_end) begin
          state_nxt   = ST_CNT_RD;
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_CNT_RD: begin
        if (sts.faces_end) begin
          state_nxt   = ST_PRE_RD;
          cmd.idx_clr = 1'b1;
        end else begin
          state_nxt = ST_CNT_O;
        end
      end
      ST_CNT_O:  state_nxt = ST_CNT_OW;
      ST_CNT_OW: state_nxt = ST_CNT_N;
      ST_CNT_N:  state_nxt = ST_CNT_NW;
      ST_CNT_NW: begin
        state_nxt   = ST_CNT_RD;
        cmd.idx_inc = 1'b1;
      end
      ST_PRE_RD: begin
        if (sts.cells_end) begin
          state_nxt   = ST_LOW_RD;
          cmd.idx_clr = 1'b1;
        end else begin
          state_nxt = ST_PRE_W;
        end
      end
      ST_PRE_W: begin
        state_nxt   = ST_PRE_RD;
        cmd.idx_inc = 1'b1;
      end
      ST_LOW_RD: begin
        if (sts.faces_end) begin
          state_nxt   = ST_DIAG_RD;
          cmd.idx_clr = 1'b1;
        end else begin
          state_nxt = ST_LOW_A;
        end
      end
      ST_LOW_A: state_nxt = ST_LOW_W;
      ST_LOW_W: begin
        state_nxt   = ST_LOW_RD;
        cmd.idx_inc = 1'b1;
      end
      ST_DIAG_RD: begin
        if (sts.cells_end) begin
          state_nxt   = ST_UP_RD;
          cmd.idx_clr = 1'b1;
        end else begin
          state_nxt = ST_DIAG_W;
        end
      end
      ST_DIAG_W: begin
        state_nxt   = ST_DIAG_RD;
        cmd.idx_inc = 1'b1;
      end
      ST_UP_RD: begin
        if (sts.faces_end) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_UP_A;
        end
      end
      ST_UP_A: state_nxt = ST_UP_W;
      ST_UP_W: begin
        state_nxt   = ST_UP_RD;
        cmd.idx_inc = 1'b1;
      end
      ST_DONE, ST_FAIL, ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/fltc_dp.sv
// Datapath with the face, count, offset, column and slot memories and the result register.
module fltc_dp #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_FACES = 16384
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fltc_pkg::cmd_t                        cmd,
  input  logic [$clog2(MAX_CELLS+1)-1:0]        cells,
  input  logic [1:0]                            in_mode,
  input  logic [fltc_pkg::CELL_BITS-1:0]        in_owner,
  input  logic [fltc_pkg::CELL_BITS-1:0]        in_neighbour,
  input  logic [2:0]                            in_sel,
  input  logic [fltc_pkg::VAL_BITS-1:0]         in_index,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [fltc_pkg::VAL_BITS-1:0]         out_value,
  output logic [fltc_pkg::VAL_BITS-1:0]         out_count,
  output logic [fltc_pkg::STS_BITS-1:0]         out_status,
  output fltc_pkg::sts_t                        sts
);
  import fltc_pkg::*;

  localparam int CW    = $clog2(MAX_CELLS + 1);
  localparam int CAW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int FCW   = $clog2(MAX_FACES + 1);
  localparam int FAW   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int COLD  = MAX_CELLS + 2 * MAX_FACES;
  localparam int COLAW = $clog2(COLD);
  localparam int EW    = $clog2(COLD + 1);
  localparam int RSAW  = $clog2(MAX_CELLS + 1);
  localparam int IW    = (FCW > CW) ? FCW : CW;
  localparam int CMPW  = 32;

  logic [IW-1:0]        idx_r, idx_nxt;
  logic [FCW-1:0]       face_total_r, face_total_nxt;
  logic [EW-1:0]        acc_r, acc_nxt;
  logic                 over_r, over_nxt;
  logic [CW-1:0]        built_cells_r, built_cells_nxt;
  logic [FCW-1:0]       built_faces_r, built_faces_nxt;
  logic [EW-1:0]        built_entries_r, built_entries_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic [2:0]           rd_sel_r, rd_sel_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VAL_BITS-1:0]  out_value_r, out_value_nxt;
  logic [VAL_BITS-1:0]  out_count_r, out_count_nxt;
  logic [STS_BITS-1:0]  out_status_r, out_status_nxt;

  logic                        face_we;
  logic [2*CELL_BITS-1:0]      face_rdata;
  logic [CELL_BITS-1:0]        own, nei;
  logic                        fill_we;
  logic [CAW-1:0]              fill_waddr, fill_raddr;
  logic [EW-1:0]               fill_wdata, fill_rdata, fill_inc;
  logic                        rs_we;
  logic [RSAW-1:0]             rs_waddr, rs_raddr;
  logic [EW-1:0]               rs_wdata, rs_rdata;
  logic                        col_we;
  logic [CELL_BITS-1:0]        col_wdata, col_rdata;
  logic [EW-1:0]               col_sum;
  logic                        diag_we, oslot_we, nslot_we;
  logic [SLOT_BITS-1:0]        diag_rdata, oslot_rdata, nslot_rdata;
  logic                        load_acc, full_acc, read_acc;
  logic [CMPW-1:0]             ix;
  logic                        range_ok;

  assign own       = face_rdata[CELL_BITS-1:0];
  assign nei       = face_rdata[2*CELL_BITS-1:CELL_BITS];
  assign fill_inc  = fill_rdata + EW'(1);
  assign col_sum   = rs_rdata + fill_rdata;
  assign ix        = CMPW'(in_index);
  assign load_acc  = cmd.accept && in_mode == MODE_LOAD && !sts.face_full;
  assign full_acc  = cmd.accept && in_mode == MODE_LOAD && sts.face_full;
  assign read_acc  = cmd.accept && in_mode == MODE_READ;
  assign face_we   = load_acc;

  assign sts.faces_end = CMPW'(idx_r) == CMPW'(face_total_r);
  assign sts.cells_end = CMPW'(idx_r) == CMPW'(cells);
  assign sts.bad_cell  = (CMPW'(own) >= CMPW'(cells)) || (CMPW'(nei) >= CMPW'(cells));
  assign sts.face_full = CMPW'(face_total_r) == CMPW'(MAX_FACES);
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    range_ok = 1'b0;
    case (in_sel)
      SEL_ROW:   range_ok = built_cells_r != '0 && ix <= CMPW'(built_cells_r);
      SEL_COL:   range_ok = ix < CMPW'(built_entries_r);
      SEL_DIAG:  range_ok = ix < CMPW'(built_cells_r);
      SEL_OSLOT: range_ok = ix < CMPW'(built_faces_r);
      SEL_NSLOT: range_ok = ix < CMPW'(built_faces_r);
      default:   range_ok = 1'b0;
    endcase
  end

  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = idx_r[CAW-1:0];
    fill_wdata = fill_inc;
    fill_raddr = idx_r[CAW-1:0];
    rs_we      = 1'b0;
    rs_waddr   = '0;
    rs_wdata   = '0;
    rs_raddr   = in_index[RSAW-1:0];
    col_we     = 1'b0;
    col_wdata  = own;
    diag_we    = 1'b0;
    oslot_we   = 1'b0;
    nslot_we   = 1'b0;
    case (cmd.op)
      ST_INIT: begin
        fill_we    = !sts.cells_end;
        fill_wdata = EW'(1);
        rs_we      = 1'b1;
      end
      ST_CNT_O: fill_raddr = CAW'(own);
      ST_CNT_OW: begin
        fill_we    = 1'b1;
        fill_waddr = CAW'(own);
      end
      ST_CNT_N: fill_raddr = CAW'(nei);
      ST_CNT_NW: begin
        fill_we    = 1'b1;
        fill_waddr = CAW'(nei);
      end
      ST_PRE_W: begin
        fill_we    = 1'b1;
        fill_wdata = '0;
        rs_we      = 1'b1;
        rs_waddr   = RSAW'(idx_r + IW'(1));
        rs_wdata   = acc_r + fill_rdata;
      end
      ST_LOW_A: begin
        fill_raddr = CAW'(nei);
        rs_raddr   = RSAW'(nei);
      end
      ST_LOW_W: begin
        fill_we    = 1'b1;
        fill_waddr = CAW'(nei);
        col_we     = 1'b1;
        col_wdata  = own;
        nslot_we   = 1'b1;
      end
      ST_DIAG_RD: rs_raddr = RSAW'(idx_r);
      ST_DIAG_W: begin
        fill_we   = 1'b1;
        col_we    = 1'b1;
        col_wdata = CELL_BITS'(idx_r);
        diag_we   = 1'b1;
      end
      ST_UP_A: begin
        fill_raddr = CAW'(own);
        rs_raddr   = RSAW'(own);
      end
      ST_UP_W: begin
        fill_we    = 1'b1;
        fill_waddr = CAW'(own);
        col_we     = 1'b1;
        col_wdata  = nei;
        oslot_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_nxt           = idx_r;
    face_total_nxt    = face_total_r;
    acc_nxt           = acc_r;
    over_nxt          = over_r;
    built_cells_nxt   = built_cells_r;
    built_faces_nxt   = built_faces_r;
    built_entries_nxt = built_entries_r;
    rd_ok_nxt         = rd_ok_r;
    rd_sel_nxt        = rd_sel_r;
    out_value_nxt     = out_value_r;
    out_count_nxt     = out_count_r;
    out_status_nxt    = out_status_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IW'(1);
    end
    if (load_acc) begin
      face_total_nxt = face_total_r + FCW'(1);
    end
    if (read_acc) begin
      rd_ok_nxt  = range_ok;
      rd_sel_nxt = in_sel;
    end
    if (full_acc) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_count_nxt  = VAL_BITS'(built_entries_r);
      out_status_nxt = STS_FULL;
    end
    case (cmd.op)
      ST_INIT: begin
        acc_nxt  = '0;
        over_nxt = 1'b0;
      end
      ST_PRE_W: begin
        acc_nxt  = acc_r + fill_rdata;
        over_nxt = over_r || fill_rdata > EW'((1 << SLOT_BITS) - 1);
      end
      ST_DONE: begin
        built_cells_nxt   = cells;
        built_faces_nxt   = face_total_r;
        built_entries_nxt = acc_r;
        out_valid_nxt     = 1'b1;
        out_value_nxt     = '0;
        out_count_nxt     = VAL_BITS'(acc_r);
        out_status_nxt    = over_r ? STS_ROW : STS_OK;
      end
      ST_FAIL: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '0;
        out_count_nxt  = '0;
        out_status_nxt = STS_CELL;
      end
      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_count_nxt  = VAL_BITS'(built_entries_r);
        out_status_nxt = rd_ok_r ? STS_OK : STS_RANGE;
        out_value_nxt  = '0;
        if (rd_ok_r) begin
          case (rd_sel_r)
            SEL_ROW:   out_value_nxt = VAL_BITS'(rs_rdata);
            SEL_COL:   out_value_nxt = VAL_BITS'(col_rdata);
            SEL_DIAG:  out_value_nxt = VAL_BITS'(diag_rdata);
            SEL_OSLOT: out_value_nxt = VAL_BITS'(oslot_rdata);
            SEL_NSLOT: out_value_nxt = VAL_BITS'(nslot_rdata);
            default:   out_value_nxt = '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r           <= '0;
      face_total_r    <= '0;
      acc_r           <= '0;
      over_r          <= 1'b0;
      built_cells_r   <= '0;
      built_faces_r   <= '0;
      built_entries_r <= '0;
      rd_ok_r         <= 1'b0;
      rd_sel_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      idx_r           <= idx_nxt;
      face_total_r    <= face_total_nxt;
      acc_r           <= acc_nxt;
      over_r          <= over_nxt;
      built_cells_r   <= built_cells_nxt;
      built_faces_r   <= built_faces_nxt;
      built_entries_r <= built_entries_nxt;
      rd_ok_r         <= rd_ok_nxt;
      rd_sel_r        <= rd_sel_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  fltc_ram #(.WIDTH(2*CELL_BITS), .DEPTH(MAX_FACES)) u_face (
    .clk(clk), .we(face_we), .waddr(face_total_r[FAW-1:0]),
    .wdata({in_neighbour, in_owner}), .raddr(idx_r[FAW-1:0]), .rdata(face_rdata)
  );

  fltc_ram #(.WIDTH(EW), .DEPTH(MAX_CELLS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );

  fltc_ram #(.WIDTH(EW), .DEPTH(MAX_CELLS + 1)) u_rows (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );

  fltc_ram #(.WIDTH(CELL_BITS), .DEPTH(COLD)) u_col (
    .clk(clk), .we(col_we), .waddr(col_sum[COLAW-1:0]), .wdata(col_wdata),
    .raddr(in_index[COLAW-1:0]), .rdata(col_rdata)
  );

  fltc_ram #(.WIDTH(SLOT_BITS), .DEPTH(MAX_CELLS)) u_diag (
    .clk(clk), .we(diag_we), .waddr(idx_r[CAW-1:0]), .wdata(fill_rdata[SLOT_BITS-1:0]),
    .raddr(in_index[CAW-1:0]), .rdata(diag_rdata)
  );

  fltc_ram #(.WIDTH(SLOT_BITS), .DEPTH(MAX_FACES)) u_oslot (
    .clk(clk), .we(oslot_we), .waddr(idx_r[FAW-1:0]), .wdata(fill_rdata[SLOT_BITS-1:0]),
    .raddr(in_index[FAW-1:0]), .rdata(oslot_rdata)
  );

  fltc_ram #(.WIDTH(SLOT_BITS), .DEPTH(MAX_FACES)) u_nslot (
    .clk(clk), .we(nslot_we), .waddr(idx_r[FAW-1:0]), .wdata(fill_rdata[SLOT_BITS-1:0]),
    .raddr(in_index[FAW-1:0]), .rdata(nslot_rdata)
  );

endmodule

>>> rtl/face_list_to_csr_pattern_unit.sv
// Top level of the face list to CSR pattern unit: stream ports, register port, assertions.
// Face loads are taken one per cycle. A read is taken only in idle; its select and range check
// are registered at accept and its result in the read state, before the next item is taken.
// A build runs in one state machine over shared single-port-write memories: a range check
// per face, seeding of the row counts per cell, counting per face, offsets per cell, lower
// entries per face, the diagonal per cell and upper entries per face. The next item waits
// while a build or read runs and while a result is held and not taken. The user must see
// that cell_count is written only while the unit is idle; the block does not enforce it.
module face_list_to_csr_pattern_unit #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_FACES = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[1:0], owner_cell[13:2], neighbour_cell[25:14],
                                  // table_select[28:26], read_index[44:29], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[15:0], nonzero_count[31:16], status[34:32], pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fltc_pkg::*;

  localparam int CW = $clog2(MAX_CELLS + 1);

  logic [12:0]          cell_count_r, cell_count_nxt;
  logic [CW-1:0]        cells;
  cmd_t                 cmd;
  sts_t                 sts;
  logic [VAL_BITS-1:0]  o_value, o_count;
  logic [STS_BITS-1:0]  o_status;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? 32'(cell_count_r) : 32'd0;

  always_comb begin
    cell_count_nxt = cell_count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0) begin
      cell_count_nxt = cfg_pwdata[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= 13'd1;
    end else begin
      cell_count_r <= cell_count_nxt;
    end
  end

  always_comb begin
    if (cell_count_r == 13'd0) begin
      cells = CW'(1);
    end else if (32'(cell_count_r) > 32'(MAX_CELLS)) begin
      cells = CW'(MAX_CELLS);
    end else begin
      cells = CW'(cell_count_r);
    end
  end

  fltc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_mode(in_tdata[1:0]),
    .sts(sts), .in_ready(in_tready), .cmd(cmd)
  );

  fltc_dp #(.MAX_CELLS(MAX_CELLS), .MAX_FACES(MAX_FACES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cells(cells),
    .in_mode(in_tdata[1:0]), .in_owner(in_tdata[13:2]), .in_neighbour(in_tdata[25:14]),
    .in_sel(in_tdata[28:26]), .in_index(in_tdata[44:29]), .out_ready(out_tready),
    .out_valid(out_tvalid), .out_value(o_value), .out_count(o_count),
    .out_status(o_status), .sts(sts)
  );

  assign out_tdata = {5'd0, o_status, o_count, o_value};

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("item accepted while result register is blocked");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34:32] == STS_RANGE) |-> out_tdata[15:0] == 16'd0)
    else $error("out of range read carries a value");

  a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34:32] == STS_CELL) |-> out_tdata[31:16] == 16'd0)
    else $error("failed build reports entries");

endmodule
